>>> src/sine_reference_pd_joint_controller_core_defines.svh
// Assertion macros for the controller's top-level RTL file.
`ifndef SINE_REFERENCE_PD_JOINT_CONTROLLER_CORE_DEFINES_SVH
`define SINE_REFERENCE_PD_JOINT_CONTROLLER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define SRPDJC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SRPDJC_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SRPDJC_ASSERT(label, prop, msg)
`define SRPDJC_ASSERT_RST(label, prop, msg)
`endif
`endif

>>> src/srpdjc_pkg.sv
// Shared constants, types and the sine table builder for the joint controller.
package srpdjc_pkg;

  localparam int SINE_TABLE_DEPTH = 1024;  // a power of two
  localparam int FRACTION_BITS    = 12;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint          PI_Q30      = 64'sd3373259426;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int TORQUE_W    = 24;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_AMPLITUDE_A   = 3'd0,
    REG_PERIOD_A      = 3'd1,
    REG_AMPLITUDE_B   = 3'd2,
    REG_PERIOD_B      = 3'd3,
    REG_GAIN_POSITION = 3'd4,
    REG_GAIN_VELOCITY = 3'd5
  } cfg_reg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // latch a request and advance both point counters
    logic joint;      // 0: joint A, 1: joint B
    logic div_start;
    logic mul_ref;    // amplitude * sine
    logic err_en;     // reference error with wrap
    logic mul_pos;    // gain_position * error
    logic mul_vel;    // gain_velocity * velocity, product of the last step kept
    logic torq_en;    // combine, round and saturate
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } status_t;

  // Long division for the series terms of the table builder.
  function automatic longint unsigned const_quotient(input longint unsigned a,
                                                     input longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = (r << 1) | ((a >> i) & 64'd1);
      if (r >= d) begin
        r = r - d;
        q = q | (64'd1 << i);
      end
    end
    return q;
  endfunction

  // One quarter-wave entry: Taylor series in Q30, rounded to Q.fbits.
  function automatic logic [31:0] sine_entry(input longint unsigned x, input int fbits);
    longint unsigned term;
    longint          sum;
    longint          r;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= 12; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = const_quotient(term, 64'((2 * n) * (2 * n + 1)));
      if (n[0] == 1'b1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    r = (sum + (longint'(1) <<< (29 - fbits))) >>> (30 - fbits);
    if (r > (longint'(1) <<< fbits)) r = longint'(1) <<< fbits;
    return 32'(r);
  endfunction

endpackage

>>> src/srpdjc_div.sv
// Restoring bit-serial divider that produces the wave phase index.
module srpdjc_div import srpdjc_pkg::*; #(
  parameter int NW = 32,
  parameter int QW = 13,
  parameter int DW = 17
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quot,
  output logic          done
);
  localparam int CW = $clog2(QW + 1);

  logic [DW-1:0] rem;
  logic [QW-1:0] low;
  logic [CW-1:0] cnt;
  logic [DW:0]   trial;
  logic          fits;

  assign trial = {rem, low[QW-1]};
  assign fits  = trial >= {1'b0, den};
  assign quot  = low;
  assign done  = cnt == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CW'(QW);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  // The quotient bits shift into the low word as the dividend bits leave it.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num[NW-1:QW];
      low <= num[QW-1:0];
    end else if (cnt != '0) begin
      rem <= fits ? DW'(trial - {1'b0, den}) : trial[DW-1:0];
      low <= {low[QW-2:0], fits};
    end
  end
endmodule

>>> src/srpdjc_ctrl.sv
// Sequencer that steps both joints through the shared divider and multiplier.
module srpdjc_ctrl import srpdjc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  status_t status,
  output logic    busy,
  output cmd_t    cmd
);
  typedef enum logic [3:0] {
    IDLE, DIV_GO, DIV_WAIT, ROM_RD, MUL_REF, ERR, MUL_P, MUL_V, TORQ, FINISH
  } state_t;

  state_t state;
  logic   joint;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      joint <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          joint <= 1'b0;
          if (in_valid) state <= DIV_GO;
        end
        DIV_GO:   state <= DIV_WAIT;
        DIV_WAIT: if (status.div_done) state <= ROM_RD;
        ROM_RD:   state <= MUL_REF;
        MUL_REF:  state <= ERR;
        ERR:      state <= MUL_P;
        MUL_P:    state <= MUL_V;
        MUL_V:    state <= TORQ;
        TORQ: begin
          joint <= 1'b1;
          state <= joint ? FINISH : DIV_GO;
        end
        FINISH:   if (status.out_free) state <= IDLE;
        default:  state <= IDLE;
      endcase
    end
  end

  assign busy = state != IDLE;

  always_comb begin
    cmd           = '0;
    cmd.joint     = joint;
    cmd.load      = (state == IDLE) && in_valid;
    cmd.div_start = state == DIV_GO;
    cmd.mul_ref   = state == MUL_REF;
    cmd.err_en    = state == ERR;
    cmd.mul_pos   = state == MUL_P;
    cmd.mul_vel   = state == MUL_V;
    cmd.torq_en   = state == TORQ;
    cmd.out_load  = (state == FINISH) && status.out_free;
  end
endmodule

>>> src/srpdjc_datapath.sv
// Registers, counters, sine table, divider, multiplier and output stage.
module srpdjc_datapath import srpdjc_pkg::*; #(
  parameter int DEPTH = SINE_TABLE_DEPTH,
  parameter int F     = FRACTION_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [CFG_INDEX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  input  logic signed [15:0]          position_a,
  input  logic signed [15:0]          velocity_a,
  input  logic signed [15:0]          position_b,
  input  logic signed [15:0]          velocity_b,
  input  cmd_t                        cmd,
  output status_t                     status,
  input  logic                        out_stall,
  output logic                        out_valid,
  output logic signed [TORQUE_W-1:0]  torque_a,
  output logic signed [TORQUE_W-1:0]  torque_b
);
  localparam int LOG_D    = $clog2(DEPTH);
  localparam int LOG_FULL = LOG_D + 2;
  localparam int QW       = LOG_FULL + 1;
  localparam int NW       = 16 + LOG_FULL + 2;
  localparam int DW       = 17;
  localparam longint PI_Q     = (PI_Q30 + (longint'(1) <<< (29 - F))) >>> (30 - F);
  localparam longint TWO_PI_Q = (2 * PI_Q30 + (longint'(1) <<< (29 - F))) >>> (30 - F);
  localparam logic signed [20:0] PI_W     = 21'(PI_Q);
  localparam logic signed [20:0] TWO_PI_W = 21'(TWO_PI_Q);
  localparam logic signed [36:0] TQ_MAX = 37'sd8388607;
  localparam logic signed [36:0] TQ_MIN = -37'sd8388608;

  logic [14:0] amplitude_a, amplitude_b;
  logic [15:0] period_a, period_b, gain_position, gain_velocity;
  logic [15:0] count_a, count_b;
  logic signed [15:0] pos_a, vel_a, pos_b, vel_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      amplitude_a   <= 15'd6144;
      period_a      <= 16'd200;
      amplitude_b   <= 15'd4096;
      period_b      <= 16'd100;
      gain_position <= 16'd2560;
      gain_velocity <= 16'd768;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_AMPLITUDE_A:   amplitude_a   <= cfg_data[14:0];
        REG_PERIOD_A:      period_a      <= cfg_data;
        REG_AMPLITUDE_B:   amplitude_b   <= cfg_data[14:0];
        REG_PERIOD_B:      period_b      <= cfg_data;
        REG_GAIN_POSITION: gain_position <= cfg_data;
        REG_GAIN_VELOCITY: gain_velocity <= cfg_data;
        default: ;
      endcase
    end
  end

  // A counter at or past its period restarts; otherwise it steps.
  always_ff @(posedge clk) begin
    if (rst) begin
      count_a <= '0;
      count_b <= '0;
    end else if (cmd.load) begin
      count_a <= (count_a >= period_a) ? '0 : count_a + 1'b1;
      count_b <= (count_b >= period_b) ? '0 : count_b + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos_a <= position_a;
      vel_a <= velocity_a;
      pos_b <= position_b;
      vel_b <= velocity_b;
    end
  end

  logic [15:0]        count_sel, period_sel;
  logic [14:0]        amp_sel;
  logic signed [15:0] pos_sel, vel_sel;

  assign count_sel  = cmd.joint ? count_b : count_a;
  assign period_sel = cmd.joint ? period_b : period_a;
  assign amp_sel    = cmd.joint ? amplitude_b : amplitude_a;
  assign pos_sel    = cmd.joint ? pos_b : pos_a;
  assign vel_sel    = cmd.joint ? vel_b : vel_a;

  // Phase = round(count * 4 * DEPTH / period), via (2*count*full + period) / (2*period).
  logic [NW-1:0] num;
  logic [QW-1:0] quot;
  logic          div_done;

  assign num = NW'({count_sel, {(LOG_FULL + 1){1'b0}}}) + NW'(period_sel);

  srpdjc_div #(.NW(NW), .QW(QW), .DW(DW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (num),
    .den   ({period_sel, 1'b0}),
    .quot  (quot),
    .done  (div_done)
  );

  logic [LOG_D-1:0] rem_idx;
  logic [1:0]       quad;
  logic [LOG_D:0]   rom_idx;
  logic [F:0]       sine_rom [DEPTH+1];
  logic [F:0]       rom_q;
  logic signed [F+1:0] sine;

  for (genvar k = 0; k <= DEPTH; k++) begin : g_rom
    localparam longint unsigned XK =
      (64'(k) * HALF_PI_Q30 + 64'(DEPTH / 2)) / 64'(DEPTH);
    localparam logic [F:0] ENTRY = (F + 1)'(sine_entry(XK, F));
    assign sine_rom[k] = ENTRY;
  end

  assign rem_idx = quot[LOG_D-1:0];
  assign quad    = quot[LOG_FULL-1:LOG_D];
  assign rom_idx = quad[0] ? (LOG_D + 1)'(DEPTH) - {1'b0, rem_idx} : {1'b0, rem_idx};

  always_ff @(posedge clk) begin
    rom_q <= sine_rom[rom_idx];
  end

  always_comb begin
    if (period_sel == '0) sine = '0;
    else if (quad[1]) sine = -$signed({1'b0, rom_q});
    else sine = $signed({1'b0, rom_q});
  end

  // Shared multiplier with a registered product.
  logic signed [17:0] mul_a, mul_b;
  logic signed [35:0] prod;
  logic signed [17:0] err;
  logic signed [35:0] acc;

  always_comb begin
    mul_a = $signed({3'b000, amp_sel});
    mul_b = 18'(sine);
    if (cmd.mul_pos) begin
      mul_a = $signed({2'b00, gain_position});
      mul_b = err;
    end else if (cmd.mul_vel) begin
      mul_a = $signed({2'b00, gain_velocity});
      mul_b = 18'(vel_sel);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_ref || cmd.mul_pos || cmd.mul_vel) prod <= mul_a * mul_b;
    if (cmd.mul_vel) acc <= prod;
  end

  // Reference rounded to nearest with ties away from zero, then error wrap.
  logic signed [35:0] ref_full;
  logic signed [20:0] err_raw, err_w1, err_w2;

  assign ref_full = (prod + 36'sd1 * (36'sd1 <<< (F - 1)) - $signed(36'(prod < 0))) >>> F;
  assign err_raw  = 21'(ref_full) - 21'(pos_sel);
  assign err_w1   = (err_raw > PI_W) ? err_raw - TWO_PI_W : err_raw;
  assign err_w2   = (err_w1 < -PI_W) ? err_w1 + TWO_PI_W : err_w1;

  always_ff @(posedge clk) begin
    if (cmd.err_en) err <= 18'(err_w2);
  end

  logic signed [36:0]         diff, tq_round;
  logic signed [TORQUE_W-1:0] tq_sat;
  logic signed [TORQUE_W-1:0] tq_a, tq_b;

  assign diff     = 37'(acc) - 37'(prod);
  assign tq_round = (diff + 37'sd128 - $signed(37'(diff < 0))) >>> 8;

  always_comb begin
    if (tq_round > TQ_MAX) tq_sat = TORQUE_W'(TQ_MAX);
    else if (tq_round < TQ_MIN) tq_sat = TORQUE_W'(TQ_MIN);
    else tq_sat = TORQUE_W'(tq_round);
  end

  always_ff @(posedge clk) begin
    if (cmd.torq_en && !cmd.joint) tq_a <= tq_sat;
    if (cmd.torq_en && cmd.joint) tq_b <= tq_sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      torque_a <= tq_a;
      torque_b <= tq_b;
    end
  end

  assign status.div_done = div_done;
  assign status.out_free = !out_valid || !out_stall;
endmodule

>>> src/sine_reference_pd_joint_controller_core.sv
// Two-joint PD position controller with a sine reference: top level.
//
// Each request carries position and velocity of joints A and B and yields one
// result with both torques. The joints are worked one after the other through
// one bit-serial divider (phase index) and one 18x18 multiplier, QW being the
// divider's quotient width, log2(4*SINE_TABLE_DEPTH)+1. The next request can
// be taken once a result is waiting; the input side stays stalled while a
// request is in work. A finished result waits in the output register, and a
// new request is taken while it waits. A further result is held back until
// the waiting one is taken. The sine table is a constant quarter-wave ROM
// with a registered read; SINE_TABLE_DEPTH must be a power of two.
`include "sine_reference_pd_joint_controller_core_defines.svh"
module sine_reference_pd_joint_controller_core import srpdjc_pkg::*; #(
  parameter int SINE_TABLE_DEPTH_P = SINE_TABLE_DEPTH,
  parameter int FRACTION_BITS_P    = FRACTION_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [CFG_INDEX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [15:0]         position_a,
  input  logic signed [15:0]         velocity_a,
  input  logic signed [15:0]         position_b,
  input  logic signed [15:0]         velocity_b,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [TORQUE_W-1:0] torque_a,
  output logic signed [TORQUE_W-1:0] torque_b
);
  cmd_t    cmd;
  status_t status;
  logic    busy;

  srpdjc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .busy     (busy),
    .cmd      (cmd)
  );

  srpdjc_datapath #(.DEPTH(SINE_TABLE_DEPTH_P), .F(FRACTION_BITS_P)) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .position_a (position_a),
    .velocity_a (velocity_a),
    .position_b (position_b),
    .velocity_b (velocity_b),
    .cmd        (cmd),
    .status     (status),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .torque_a   (torque_a),
    .torque_b   (torque_b)
  );

  assign in_stall = busy;

  `SRPDJC_ASSERT(a_busy_after_accept, (in_valid && !in_stall) |=> in_stall, "accepted request did not start work")
  `SRPDJC_ASSERT(a_result_from_work, $rose(out_valid) |-> $past(in_stall), "result appeared without work in progress")
  `SRPDJC_ASSERT_RST(a_reset_clears, rst |=> (!out_valid && !in_stall), "reset left control state set")
endmodule
